// ----- sv/rtc_disciplined_timer_calibrator_core_assert.svh -----
// ----------------------------------------------------------------------------
// rtc_disciplined_timer_calibrator_core_assert.svh
// Assertion macros used by the calibrator checker.
// ----------------------------------------------------------------------------
`ifndef RTC_DISCIPLINED_TIMER_CALIBRATOR_CORE_ASSERT_SVH
`define RTC_DISCIPLINED_TIMER_CALIBRATOR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTCDTC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define RTCDTC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/rtcdtc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcdtc_pkg
// Types and constants of the RTC disciplined timer calibrator.
// ----------------------------------------------------------------------------
package rtcdtc_pkg;

	localparam int CAL_COUNT_WIDTH = 32;
	localparam int CFG_INDEX_W     = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_PRESCALER_RESET = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STABLE_LIMIT    = 2'd1;

	localparam logic [15:0] STABLE_LIMIT_RESET = 16'd1800;
	localparam logic [32:0] NS_PER_SEC         = 33'd1000000000;

	localparam logic OP_SECOND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [1:0] PH_TICK   = 2'd0;
	localparam logic [1:0] PH_TOCK   = 2'd1;
	localparam logic [1:0] PH_INIT   = 2'd2;
	localparam logic [1:0] PH_NOINIT = 2'd3;

	typedef struct packed {
		logic        op;
		logic [31:0] timer_count;
		logic [31:0] rtc_seconds;
	} cal_in_t;

	typedef struct packed {
		logic [31:0] seconds;
		logic [31:0] nanoseconds;
		logic [31:0] prescaler_value;
		logic        restart_timer;
		logic [31:0] ticks_per_second;
	} cal_out_t;

endpackage

// ----- sv/rtc_disciplined_timer_calibrator_core.sv -----
// ----------------------------------------------------------------------------
// rtc_disciplined_timer_calibrator_core
// Trims a fast timer against an RTC second pulse and converts timer counts
// to nanoseconds, using one shared 34-bit add/subtract unit.
// ----------------------------------------------------------------------------
//  channel  | signals                         | direction
//  in       | in_valid, in_ready, in_data     | request in
//  out      | out_valid, out_ready, out_data  | result out
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register write in
//
// A request with no rescale and no read conversion goes straight to S_FIN. A
// read with a nonzero tick estimate, or a tock that rescales, runs
// 32 shift-add multiply steps, then 64 restoring divide steps, on the shared
// adder. in_ready is low while a request is in work; a result waits in the
// output register while out_ready is low. Reset is asynchronous, active low.
// ----------------------------------------------------------------------------
module rtc_disciplined_timer_calibrator_core
	import rtcdtc_pkg::*;
#(
	parameter int COUNT_WIDTH = CAL_COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  cal_in_t                in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output cal_out_t               out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam int MUL_STEPS = 32;
	localparam int DIV_STEPS = 64;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]        st_q;
	logic [STEP_W-1:0] step_q;
	logic              job_read_q;

	logic [15:0] stable_limit_q;
	logic [31:0] seconds_q;
	logic [31:0] tick_q;
	logic [31:0] prescaler_q;
	logic [1:0]  phase_q;
	logic [16:0] stable_q;

	logic [31:0] nsec_q;
	logic        restart_q;
	logic        out_valid_q;
	cal_out_t    out_q;

	logic [65:0] acc_q;
	logic [32:0] rem_q;
	logic [32:0] mulb_q;
	logic [32:0] dvsr_q;

	logic [31:0]        count;
	logic [31:0]        diff;
	logic signed [31:0] half;
	logic [31:0]        t_half;
	logic [31:0]        t_adj;
	logic [16:0]        sc_inc;
	logic [33:0]        div_r;
	logic [33:0]        alu_x;
	logic [33:0]        alu_y;
	logic [34:0]        alu_sum;
	logic               in_acc;
	logic               out_load;

	assign in_ready  = (st_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_acc    = in_valid && in_ready;
	assign out_load  = (st_q == S_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		count  = in_data.timer_count & CNT_MASK;
		diff   = count - tick_q;
		half   = ($signed(diff) + $signed({31'd0, diff[31]})) >>> 1;
		t_half = tick_q + $unsigned(half);
		t_adj  = (t_half == tick_q) ? t_half + 32'd1 : t_half;
		sc_inc = stable_q + 17'd1;
	end

	// shared adder: accumulate in multiply, trial subtract in divide
	always_comb begin
		div_r = {rem_q, acc_q[63]};
		if (st_q == S_MUL) begin
			alu_x = acc_q[65:32];
			alu_y = acc_q[0] ? {1'b0, mulb_q} : 34'd0;
		end else begin
			alu_x = div_r;
			alu_y = ~{1'b0, dvsr_q};
		end
		alu_sum = {1'b0, alu_x} + {1'b0, alu_y} + 35'(st_q == S_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= S_IDLE;
			step_q         <= '0;
			job_read_q     <= 1'b0;
			stable_limit_q <= STABLE_LIMIT_RESET;
			seconds_q      <= '0;
			tick_q         <= '0;
			prescaler_q    <= '0;
			phase_q        <= PH_NOINIT;
			stable_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PRESCALER_RESET: prescaler_q <= cfg_data;
					REG_STABLE_LIMIT: stable_limit_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (in_acc) begin
						step_q     <= '0;
						job_read_q <= (in_data.op == OP_READ);
						st_q       <= S_FIN;
						if (in_data.op == OP_READ) begin
							if (tick_q != 32'd0) begin
								acc_q  <= {34'd0, count};
								mulb_q <= NS_PER_SEC;
								dvsr_q <= {1'b0, tick_q};
								st_q   <= S_MUL;
							end
						end else begin
							seconds_q <= seconds_q + 32'd1;
							case (phase_q)
								PH_TICK:   phase_q <= PH_TOCK;
								PH_NOINIT: phase_q <= PH_INIT;
								PH_INIT: begin
									seconds_q <= in_data.rtc_seconds;
									tick_q    <= diff;
									phase_q   <= PH_TOCK;
								end
								PH_TOCK: begin
									phase_q <= PH_TICK;
									if (diff == 32'd0) begin
										if (sc_inc > {1'b0, stable_limit_q}) begin
											stable_q <= '0;
											if (prescaler_q != 32'd0) begin
												acc_q       <= {34'd0, tick_q};
												mulb_q      <= {1'b0, prescaler_q} + 33'd1;
												dvsr_q      <= {1'b0, prescaler_q};
												prescaler_q <= prescaler_q - 32'd1;
												st_q        <= S_MUL;
											end
										end else begin
											stable_q <= sc_inc;
										end
									end else if (diff == 32'd1) begin
										tick_q <= tick_q + 32'd1;
									end else if (diff == 32'hFFFF_FFFF) begin
										tick_q <= tick_q - 32'd1;
									end else begin
										stable_q <= '0;
										if (prescaler_q != 32'hFFFF_FFFF) begin
											acc_q       <= {34'd0, t_adj};
											mulb_q      <= {1'b0, prescaler_q} + 33'd1;
											dvsr_q      <= {1'b0, prescaler_q} + 33'd2;
											prescaler_q <= prescaler_q + 32'd1;
											st_q        <= S_MUL;
										end else begin
											tick_q <= t_adj;
										end
									end
								end
								default: ;
							endcase
						end
					end
				end
				S_MUL: begin
					acc_q  <= {1'b0, alu_sum[33:0], acc_q[31:1]};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(MUL_STEPS - 1)) begin
						step_q <= '0;
						rem_q  <= '0;
						st_q   <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= alu_sum[34] ? alu_sum[32:0] : div_r[32:0];
					acc_q  <= {2'b00, acc_q[62:0], alu_sum[34]};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						if (!job_read_q)
							tick_q <= {acc_q[30:0], alu_sum[34]};
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load)
						st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// payload side: no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			nsec_q    <= '0;
			restart_q <= (in_data.op == OP_SECOND);
		end
		if (st_q == S_DIV && step_q == STEP_W'(DIV_STEPS - 1) && job_read_q)
			nsec_q <= {acc_q[30:0], alu_sum[34]};
		if (out_load) begin
			out_q.seconds          <= seconds_q;
			out_q.nanoseconds      <= nsec_q;
			out_q.prescaler_value  <= prescaler_q;
			out_q.restart_timer    <= restart_q;
			out_q.ticks_per_second <= tick_q;
		end
	end

endmodule

// ----- sv/rtcdtc_checker.sv -----
// ----------------------------------------------------------------------------
// rtcdtc_checker
// Port-level checks on the calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rtc_disciplined_timer_calibrator_core_assert.svh"

module rtcdtc_checker
	import rtcdtc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input cal_out_t out_data
);

	// one request in work at a time
	`RTCDTC_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

	// no result without an estimate can carry a time fraction
	`RTCDTC_ASSERT_IMPL(a_ns_zero_tick, out_valid && (out_data.ticks_per_second == 32'd0), out_data.nanoseconds == 32'd0)

	// second events always restart the timer with a zero fraction
	`RTCDTC_ASSERT_IMPL(a_restart_ns, out_valid && out_data.restart_timer, out_data.nanoseconds == 32'd0)

	// a held result stays put
	`RTCDTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind rtc_disciplined_timer_calibrator_core rtcdtc_checker u_rtcdtc_checker (.*);
